// File: design/tsot_pkg.sv
// Package for the triangle/sphere overlap test: widths, payload types,
// index constants and the stage structs. No dependencies.
package tsot_pkg;

	localparam int CRD_W   = 32;
	localparam int DIF_W   = CRD_W + 1;
	localparam int PRD_W   = 2 * DIF_W;
	localparam int SUM_W   = PRD_W + 2;
	localparam int RAD_W   = 32;
	localparam int R2_W    = 2 * RAD_W;
	localparam int THR_W   = 20;
	localparam logic [THR_W-1:0] THR_RST = THR_W'(4295);
	localparam int MUL_W   = 140;
	localparam int LIMB_W  = 35;
	localparam int LIMBS   = MUL_W / LIMB_W;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int MUL_LAT = 3;

	// Dot product slots: squared corner distances, squared edge lengths,
	// and the projections of the corner offsets on the edges.
	localparam int D_AA  = 0;
	localparam int D_LAB = 3;
	localparam int D_DAB = 6;
	localparam int N_DOT = 9;

	// Cross product slots: normal, then the side vectors of edges AB, BC and CA.
	localparam int C_N  = 0;
	localparam int C_EA = 1;
	localparam int N_CRS = 4;

	typedef logic signed [CRD_W-1:0] crd_t;
	typedef logic signed [DIF_W-1:0] dif_t;
	typedef logic signed [PRD_W-1:0] prd_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [MUL_W-1:0] mop_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [2:0][DIF_W-1:0] dvec_t;

	// Everything the first three stages produce for one item.
	typedef struct packed {
		logic [N_DOT-1:0][SUM_W-1:0]      dt;
		logic [N_CRS-1:0][2:0][SUM_W-1:0] cr;
		dvec_t                            a;
		logic [R2_W-1:0]                  r2;
	} geom_t;

	// Early decision flags; deg and rng are indexed by edge AB, BC, CA.
	typedef struct packed {
		logic       corner;
		logic [2:0] deg;
		logic       vor;
		logic [2:0] rng;
	} flg1_t;

	typedef struct packed {
		flg1_t      f;
		logic [2:0] near;
		logic [2:0] pos;
		logic       flat;
	} flg2_t;

endpackage

// File: design/tsot_mul.sv
// Pipelined signed multiplier of MUL_W by MUL_W bits.
// Sign and magnitude form, limb partial products, then row and final sums.
// Depends on tsot_pkg.
module tsot_mul (
	input  logic           clk,
	input  tsot_pkg::mop_t a,
	input  tsot_pkg::mop_t b,
	output tsot_pkg::prod_t p
);
	import tsot_pkg::*;

	logic [MUL_W-1:0] ma, mb;
	logic [2*LIMB_W-1:0] pp_s1 [LIMBS][LIMBS];
	logic neg_s1, neg_s2;
	logic [PROD_W-1:0] row_c [LIMBS];
	logic [PROD_W-1:0] row_s2 [LIMBS];
	logic [PROD_W-1:0] tot_c;
	prod_t p_s3;

	// Magnitudes of both operands.
	always_comb begin
		ma = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
		mb = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
	end

	// Stage 1: limb by limb partial products.
	always_ff @(posedge clk) begin
		for (int i = 0; i < LIMBS; i++) begin
			for (int j = 0; j < LIMBS; j++) begin
				pp_s1[i][j] <= (2*LIMB_W)'(ma[i*LIMB_W +: LIMB_W]) *
					(2*LIMB_W)'(mb[j*LIMB_W +: LIMB_W]);
			end
		end
		neg_s1 <= a[MUL_W-1] ^ b[MUL_W-1];
	end

	// Stage 2: one shifted sum per row.
	always_comb begin
		for (int i = 0; i < LIMBS; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < LIMBS; j++) begin
				row_c[i] = row_c[i] + (PROD_W'(pp_s1[i][j]) << (LIMB_W * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LIMBS; i++) begin
			row_s2[i] <= row_c[i];
		end
		neg_s2 <= neg_s1;
	end

	// Stage 3: add the rows and restore the sign.
	always_comb begin
		tot_c = '0;
		for (int i = 0; i < LIMBS; i++) begin
			tot_c = tot_c + row_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		p_s3 <= neg_s2 ? prod_t'(-tot_c) : prod_t'(tot_c);
	end

	assign p = p_s3;

endmodule

// File: design/tsot_geom.sv
// Front stages of the overlap test: corner offsets and edge vectors,
// their products, then dot and cross product sums. Depends on tsot_pkg.
module tsot_geom (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  tsot_pkg::crd_t            ax,
	input  tsot_pkg::crd_t            ay,
	input  tsot_pkg::crd_t            az,
	input  tsot_pkg::crd_t            bx,
	input  tsot_pkg::crd_t            by,
	input  tsot_pkg::crd_t            bz,
	input  tsot_pkg::crd_t            cx,
	input  tsot_pkg::crd_t            cy,
	input  tsot_pkg::crd_t            cz,
	input  tsot_pkg::crd_t            px,
	input  tsot_pkg::crd_t            py,
	input  tsot_pkg::crd_t            pz,
	input  logic [tsot_pkg::RAD_W-1:0] rad,
	output logic                      out_vld,
	output tsot_pkg::geom_t           g
);
	import tsot_pkg::*;

	function automatic logic [DIF_W-1:0] sub(input crd_t x, input crd_t y);
		dif_t xe, ye;
		xe = x;
		ye = y;
		return xe - ye;
	endfunction

	function automatic prd_t mul(input logic [DIF_W-1:0] x, input logic [DIF_W-1:0] y);
		prd_t xe, ye;
		xe = $signed(x);
		ye = $signed(y);
		return xe * ye;
	endfunction

	// Vector slots: a, b, c (centre minus corner), then ab, bc, ca.
	dvec_t v_c [6];
	dvec_t v_s1 [6];
	logic [R2_W-1:0] r2_s1, r2_s2;
	logic v1_q, v2_q, v3_q;
	dvec_t a_s2;
	prd_t dp_s2 [N_DOT][3];
	prd_t cp_s2 [N_CRS][6];
	geom_t g_s3;

	// Stage 1: differences and the squared radius.
	always_comb begin
		v_c[0] = {sub(pz, az), sub(py, ay), sub(px, ax)};
		v_c[1] = {sub(pz, bz), sub(py, by), sub(px, bx)};
		v_c[2] = {sub(pz, cz), sub(py, cy), sub(px, cx)};
		v_c[3] = {sub(bz, az), sub(by, ay), sub(bx, ax)};
		v_c[4] = {sub(cz, bz), sub(cy, by), sub(cx, bx)};
		v_c[5] = {sub(az, cz), sub(ay, cy), sub(ax, cx)};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			v_s1[i] <= v_c[i];
		end
		r2_s1 <= R2_W'(rad) * R2_W'(rad);
	end

	// Stage 2: all component products. Dots pair a,b,c,ab,bc,ca with
	// themselves, then a,b,c with ab,bc,ca; crosses are ca x ab and
	// a x ab, b x bc, c x ca.
	always_ff @(posedge clk) begin
		for (int i = 0; i < N_DOT; i++) begin
			for (int k = 0; k < 3; k++) begin
				dp_s2[i][k] <= mul(v_s1[i % 6][k], v_s1[(i < 6) ? i : i - 3][k]);
			end
		end
		for (int i = 0; i < N_CRS; i++) begin
			cp_s2[i][0] <= mul(v_s1[(i == 0) ? 5 : i - 1][1], v_s1[(i == 0) ? 3 : i + 2][2]);
			cp_s2[i][1] <= mul(v_s1[(i == 0) ? 5 : i - 1][2], v_s1[(i == 0) ? 3 : i + 2][1]);
			cp_s2[i][2] <= mul(v_s1[(i == 0) ? 5 : i - 1][2], v_s1[(i == 0) ? 3 : i + 2][0]);
			cp_s2[i][3] <= mul(v_s1[(i == 0) ? 5 : i - 1][0], v_s1[(i == 0) ? 3 : i + 2][2]);
			cp_s2[i][4] <= mul(v_s1[(i == 0) ? 5 : i - 1][0], v_s1[(i == 0) ? 3 : i + 2][1]);
			cp_s2[i][5] <= mul(v_s1[(i == 0) ? 5 : i - 1][1], v_s1[(i == 0) ? 3 : i + 2][0]);
		end
		a_s2  <= v_s1[0];
		r2_s2 <= r2_s1;
	end

	// Stage 3: sums and differences of the products.
	always_ff @(posedge clk) begin
		for (int i = 0; i < N_DOT; i++) begin
			g_s3.dt[i] <= sum_t'(dp_s2[i][0]) + sum_t'(dp_s2[i][1]) + sum_t'(dp_s2[i][2]);
		end
		for (int i = 0; i < N_CRS; i++) begin
			for (int k = 0; k < 3; k++) begin
				g_s3.cr[i][k] <= sum_t'(cp_s2[i][2*k]) - sum_t'(cp_s2[i][2*k+1]);
			end
		end
		g_s3.a  <= a_s2;
		g_s3.r2 <= r2_s2;
	end

	// Valid bits follow the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			v1_q <= in_vld;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	assign out_vld = v3_q;
	assign g       = g_s3;

endmodule

// File: design/triangle_sphere_overlap_test.sv
// Top level of the triangle/sphere strict overlap test.
// Uses tsot_pkg, tsot_geom (front stages) and tsot_mul (wide products).
//
// Channel    Direction  Handshake             Payload
// item in    input      start, busy           vertex_*, center_x, center_y,
//                                             center_z_and_radius
// result     output     done (strobe)         overlaps
// config     input      cfg_valid, cfg_ready  cfg_data (degenerate threshold)
//
// One item is taken every cycle; busy stays low. The answer appears on done
// after three front stages, two rounds of the three-stage multiplier with a
// sum stage between, and the output register.
// Reset clears the valid bits and loads the threshold with its default.
// The receiver cannot stall, so the pipeline never holds.
module triangle_sphere_overlap_test (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  tsot_pkg::crd_t             vertex_a_x,
	input  tsot_pkg::crd_t             vertex_a_y,
	input  tsot_pkg::crd_t             vertex_a_z,
	input  tsot_pkg::crd_t             vertex_b_x,
	input  tsot_pkg::crd_t             vertex_b_y,
	input  tsot_pkg::crd_t             vertex_b_z,
	input  tsot_pkg::crd_t             vertex_c_x,
	input  tsot_pkg::crd_t             vertex_c_y,
	input  tsot_pkg::crd_t             vertex_c_z,
	input  tsot_pkg::crd_t             center_x,
	input  tsot_pkg::crd_t             center_y,
	input  logic [63:0]                center_z_and_radius,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tsot_pkg::THR_W-1:0] cfg_data,
	output logic                       done,
	output logic                       overlaps
);
	import tsot_pkg::*;

	// Product slots of the first multiplier round.
	localparam int M_NN = 0;
	localparam int M_AN = 3;
	localparam int M_EX = 6;
	localparam int M_NR = 15;
	localparam int N_M1 = 24;

	logic [THR_W-1:0] thr_q, th_eff;
	logic   v3;
	geom_t  g3;
	flg1_t  f1_c;
	mop_t   m1a [N_M1];
	mop_t   m1b [N_M1];
	prod_t  m1p [N_M1];
	flg1_t  f1_d [MUL_LAT];
	logic [R2_W-1:0] r2_d [MUL_LAT];
	logic   v1_d [MUL_LAT];
	prod_t  n2_c, pd_c, thn;
	prod_t  n2_s6, pd_s6;
	flg2_t  f2_s6;
	logic [R2_W-1:0] r2_s6;
	logic   v6_q;
	prod_t  pp, rn;
	flg2_t  f2_d [MUL_LAT];
	logic   v2_d [MUL_LAT];
	flg2_t  fz;
	logic   res_c;
	logic   done_q, ovl_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Threshold register; zero acts as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end
	assign th_eff = (thr_q == '0) ? THR_W'(1) : thr_q;
	assign thn = {{(PROD_W-THR_W-32){1'b0}}, th_eff, 32'b0};

	tsot_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start && !busy),
		.ax     (vertex_a_x),
		.ay     (vertex_a_y),
		.az     (vertex_a_z),
		.bx     (vertex_b_x),
		.by     (vertex_b_y),
		.bz     (vertex_b_z),
		.cx     (vertex_c_x),
		.cy     (vertex_c_y),
		.cz     (vertex_c_z),
		.px     (center_x),
		.py     (center_y),
		.pz     (crd_t'(center_z_and_radius[63:32])),
		.rad    (center_z_and_radius[31:0]),
		.out_vld(v3),
		.g      (g3)
	);

	// Early flags: corner hits, short edges, corner regions, edge ranges.
	always_comb begin
		f1_c.corner = 1'b0;
		f1_c.vor    = 1'b0;
		for (int e = 0; e < 3; e++) begin
			f1_c.corner = f1_c.corner ||
				($signed(g3.dt[D_AA+e]) < $signed({4'b0, g3.r2}));
			f1_c.deg[e] = $signed(g3.dt[D_LAB+e]) <
				$signed({{(SUM_W-THR_W){1'b0}}, th_eff});
			f1_c.rng[e] = ($signed(g3.dt[D_DAB+e]) > $signed(sum_t'(0))) &&
				($signed(g3.dt[D_DAB+e]) < $signed(g3.dt[D_LAB+e]));
			f1_c.vor = f1_c.vor ||
				(($signed(g3.dt[D_DAB+e]) >= $signed(g3.dt[D_LAB+e])) &&
				 ($signed(g3.dt[D_DAB+((e == 2) ? 0 : e + 1)]) <= $signed(sum_t'(0))));
		end
	end

	// Operands of the first multiplier round.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m1a[M_NN+k] = mop_t'($signed(g3.cr[C_N][k]));
			m1b[M_NN+k] = mop_t'($signed(g3.cr[C_N][k]));
			m1a[M_AN+k] = mop_t'($signed(g3.a[k]));
			m1b[M_AN+k] = mop_t'($signed(g3.cr[C_N][k]));
		end
		for (int e = 0; e < 3; e++) begin
			for (int k = 0; k < 3; k++) begin
				m1a[M_EX+3*e+k] = mop_t'($signed(g3.cr[C_EA+e][k]));
				m1b[M_EX+3*e+k] = mop_t'($signed(g3.cr[C_N][k]));
			end
			m1a[M_NR+3*e]   = mop_t'($signed(g3.dt[D_AA+e]));
			m1b[M_NR+3*e]   = mop_t'($signed(g3.dt[D_LAB+e]));
			m1a[M_NR+3*e+1] = mop_t'($signed(g3.dt[D_DAB+e]));
			m1b[M_NR+3*e+1] = mop_t'($signed(g3.dt[D_DAB+e]));
			m1a[M_NR+3*e+2] = mop_t'($signed({1'b0, g3.r2}));
			m1b[M_NR+3*e+2] = mop_t'($signed(g3.dt[D_LAB+e]));
		end
	end

	for (genvar i = 0; i < N_M1; i++) begin : g_m1
		tsot_mul u_mul (.clk(clk), .a(m1a[i]), .b(m1b[i]), .p(m1p[i]));
	end

	// Flags and squared radius wait alongside the first round.
	always_ff @(posedge clk) begin
		f1_d[0] <= f1_c;
		r2_d[0] <= g3.r2;
		for (int i = 1; i < MUL_LAT; i++) begin
			f1_d[i] <= f1_d[i-1];
			r2_d[i] <= r2_d[i-1];
		end
	end

	// Sum stage: squared normal, plane distance, edge sides, line tests.
	assign n2_c = m1p[M_NN] + m1p[M_NN+1] + m1p[M_NN+2];
	assign pd_c = m1p[M_AN] + m1p[M_AN+1] + m1p[M_AN+2];

	always_ff @(posedge clk) begin
		n2_s6   <= n2_c;
		pd_s6   <= pd_c;
		r2_s6   <= r2_d[MUL_LAT-1];
		f2_s6.f <= f1_d[MUL_LAT-1];
		f2_s6.flat <= n2_c < thn;
		for (int e = 0; e < 3; e++) begin
			f2_s6.pos[e] <= (m1p[M_EX+3*e] + m1p[M_EX+3*e+1] + m1p[M_EX+3*e+2]) >
				prod_t'(0);
			f2_s6.near[e] <= (m1p[M_NR+3*e] - m1p[M_NR+3*e+1]) < m1p[M_NR+3*e+2];
		end
	end

	// Second round: plane distance squared against radius squared times normal squared.
	tsot_mul u_mul_pd (
		.clk(clk),
		.a  (pd_s6[MUL_W-1:0]),
		.b  (pd_s6[MUL_W-1:0]),
		.p  (pp)
	);

	tsot_mul u_mul_rn (
		.clk(clk),
		.a  (mop_t'($signed({1'b0, r2_s6}))),
		.b  (n2_s6[MUL_W-1:0]),
		.p  (rn)
	);

	always_ff @(posedge clk) begin
		f2_d[0] <= f2_s6;
		for (int i = 1; i < MUL_LAT; i++) begin
			f2_d[i] <= f2_d[i-1];
		end
	end

	// Final decision in the order of the checks.
	assign fz = f2_d[MUL_LAT-1];
	always_comb begin
		priority if (fz.f.corner) begin
			res_c = 1'b1;
		end else if (fz.f.deg[0]) begin
			res_c = !fz.f.deg[1] && fz.f.rng[1] && fz.near[1];
		end else if (fz.f.deg[1]) begin
			res_c = !fz.f.deg[2] && fz.f.rng[2] && fz.near[2];
		end else if (fz.f.deg[2]) begin
			res_c = fz.f.rng[0] && fz.near[0];
		end else if (fz.f.vor) begin
			res_c = 1'b0;
		end else if (fz.flat) begin
			res_c = fz.near[0];
		end else if (pp >= rn) begin
			res_c = 1'b0;
		end else if (fz.pos[0]) begin
			res_c = fz.f.rng[0] && fz.near[0];
		end else if (fz.pos[1]) begin
			res_c = fz.f.rng[1] && fz.near[1];
		end else if (fz.pos[2]) begin
			res_c = fz.f.rng[2] && fz.near[2];
		end else begin
			res_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		ovl_q <= res_c;
	end

	// Valid bits through both multiplier rounds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MUL_LAT; i++) begin
				v1_d[i] <= 1'b0;
				v2_d[i] <= 1'b0;
			end
			v6_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v1_d[0] <= v3;
			v2_d[0] <= v6_q;
			for (int i = 1; i < MUL_LAT; i++) begin
				v1_d[i] <= v1_d[i-1];
				v2_d[i] <= v2_d[i-1];
			end
			v6_q   <= v1_d[MUL_LAT-1];
			done_q <= v2_d[MUL_LAT-1];
		end
	end

	assign done     = done_q;
	assign overlaps = ovl_q;

	// Each result goes back to an item accepted earlier.
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2*MUL_LAT + 5))
		else $error("result without a matching item");

	// The sum stage only fires for items that left the front stages.
	a_mid_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v6_q |-> $past(v3, MUL_LAT + 1))
		else $error("sum stage valid out of step");

endmodule

// File: verif/triangle_sphere_overlap_checker.sv
// Checker for the triangle/sphere overlap test: watches the item, result and
// threshold channels, predicts each answer exactly and compares. Uses tsot_pkg.
module triangle_sphere_overlap_checker
	import tsot_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  crd_t              vertex_a_x,
	input  crd_t              vertex_a_y,
	input  crd_t              vertex_a_z,
	input  crd_t              vertex_b_x,
	input  crd_t              vertex_b_y,
	input  crd_t              vertex_b_z,
	input  crd_t              vertex_c_x,
	input  crd_t              vertex_c_y,
	input  crd_t              vertex_c_z,
	input  crd_t              center_x,
	input  crd_t              center_y,
	input  logic [63:0]       center_z_and_radius,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [THR_W-1:0]  cfg_data,
	input  logic              done,
	input  logic              overlaps,
	output int                fail_count,
	output int                pending_answers
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [255:0] wide_t;
	typedef wide_t vec_t [3];

	logic [THR_W-1:0] threshold;
	logic             answer_q [$];

	assign pending_answers = answer_q.size();

	function automatic wide_t dot3(vec_t p, vec_t q);
		return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
	endfunction

	function automatic vec_t cross3(vec_t p, vec_t q);
		vec_t r;
		r[0] = p[1] * q[2] - p[2] * q[1];
		r[1] = p[2] * q[0] - p[0] * q[2];
		r[2] = p[0] * q[1] - p[1] * q[0];
		return r;
	endfunction

	function automatic vec_t sub3(vec_t p, vec_t q);
		vec_t r;
		for (int i = 0; i < 3; i++) r[i] = p[i] - q[i];
		return r;
	endfunction

	// Distance from the line below the radius, with the division multiplied out.
	function automatic logic line_near(vec_t p, wide_t d, wide_t len, wide_t r2);
		return dot3(p, p) * len - d * d < r2 * len;
	endfunction

	// Edge cylinder, the foot point strictly inside the edge.
	function automatic logic cylinder_hit(vec_t p, vec_t s, wide_t len, wide_t r2);
		wide_t d;
		d = dot3(p, s);
		if (d <= 0 || d >= len) return 1'b0;
		return line_near(p, d, len, r2);
	endfunction

	function automatic logic sphere_overlaps(vec_t va, vec_t vb, vec_t vc, vec_t pc,
			logic [31:0] rad, logic [THR_W-1:0] thr_reg);
		wide_t r2, thr, thrn, lab, lbc, lca, dab, dbc, dca, n2, pd;
		vec_t a, b, c, sab, sbc, sca, n;
		r2 = wide_t'({224'd0, rad}) * wide_t'({224'd0, rad});
		thr = (thr_reg == 0) ? wide_t'(1) : wide_t'({236'd0, thr_reg});
		thrn = thr <<< 32;
		a = sub3(pc, va);
		b = sub3(pc, vb);
		c = sub3(pc, vc);
		sab = sub3(vb, va);
		sbc = sub3(vc, vb);
		sca = sub3(va, vc);
		if (dot3(a, a) < r2 || dot3(b, b) < r2 || dot3(c, c) < r2) return 1'b1;
		lab = dot3(sab, sab);
		lbc = dot3(sbc, sbc);
		lca = dot3(sca, sca);
		// Short edges collapse the triangle to one edge or a point.
		if (lab < thr) begin
			if (lbc < thr) return 1'b0;
			return cylinder_hit(b, sbc, lbc, r2);
		end
		if (lbc < thr) begin
			if (lca < thr) return 1'b0;
			return cylinder_hit(c, sca, lca, r2);
		end
		if (lca < thr) return cylinder_hit(a, sab, lab, r2);
		// Corner outer regions.
		dab = dot3(a, sab);
		dbc = dot3(b, sbc);
		dca = dot3(c, sca);
		if (dab >= lab && dbc <= 0) return 1'b0;
		if (dbc >= lbc && dca <= 0) return 1'b0;
		if (dca >= lca && dab <= 0) return 1'b0;
		n = cross3(sca, sab);
		n2 = dot3(n, n);
		if (n2 < thrn) return line_near(a, dab, lab, r2);
		pd = dot3(a, n);
		if (pd * pd >= r2 * n2) return 1'b0;
		if (dot3(cross3(a, sab), n) > 0) return cylinder_hit(a, sab, lab, r2);
		if (dot3(cross3(b, sbc), n) > 0) return cylinder_hit(b, sbc, lbc, r2);
		if (dot3(cross3(c, sca), n) > 0) return cylinder_hit(c, sca, lca, r2);
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// Threshold shadow, item prediction and answer comparison.
	always @(posedge clk or negedge arst_n) begin
		vec_t va, vb, vc, pc;
		logic want;
		logic predicted;
		if (!arst_n) begin
			threshold = THR_RST;
			answer_q.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (answer_q.size() == 0) begin
					report_mismatch("answer with no item waiting");
				end else begin
					want = answer_q.pop_front();
					if (overlaps !== want)
						report_mismatch($sformatf("overlaps %b, expected %b", overlaps, want));
				end
			end
			if (start && !busy) begin
				va[0] = vertex_a_x; va[1] = vertex_a_y; va[2] = vertex_a_z;
				vb[0] = vertex_b_x; vb[1] = vertex_b_y; vb[2] = vertex_b_z;
				vc[0] = vertex_c_x; vc[1] = vertex_c_y; vc[2] = vertex_c_z;
				pc[0] = center_x; pc[1] = center_y;
				pc[2] = $signed(center_z_and_radius[63:32]);
				predicted = sphere_overlaps(va, vb, vc, pc,
					center_z_and_radius[31:0], threshold);
				answer_q = {answer_q, predicted};
			end
			if (cfg_valid && cfg_ready) threshold = cfg_data;
		end
	end

endmodule

// File: verif/triangle_sphere_overlap_test_tb.sv
// Testbench top for the triangle/sphere overlap test: clock, reset, items and
// threshold writes, and the verdict. Uses tsot_pkg and the overlap checker.
module triangle_sphere_overlap_test_tb;
	import tsot_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	crd_t vertex_a_x = '0, vertex_a_y = '0, vertex_a_z = '0;
	crd_t vertex_b_x = '0, vertex_b_y = '0, vertex_b_z = '0;
	crd_t vertex_c_x = '0, vertex_c_y = '0, vertex_c_z = '0;
	crd_t center_x = '0, center_y = '0;
	logic [63:0] center_z_and_radius = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [THR_W-1:0] cfg_data = '0;
	logic done;
	logic overlaps;
	int fail_count;
	int pending_answers;
	int quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	triangle_sphere_overlap_test dut (.*);

	triangle_sphere_overlap_checker checker_i (.*);

	// Watchdog on cycles with no accepted item, result or write.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Small coordinate around a base, mostly fractional scale.
	function automatic crd_t near_crd(crd_t base, int span);
		return base + crd_t'($signed($urandom_range(2 * span, 0)) - span);
	endfunction

	// Start stays high after an item so that the next one can follow at once;
	// it drops only for a gap or when the caller ends a run of items.
	task automatic send_item(crd_t ax, crd_t ay, crd_t az, crd_t bx, crd_t by, crd_t bz,
			crd_t cx, crd_t cy, crd_t cz, crd_t px, crd_t py, crd_t pz,
			logic [31:0] rad, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(13, 0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		vertex_a_x <= ax; vertex_a_y <= ay; vertex_a_z <= az;
		vertex_b_x <= bx; vertex_b_y <= by; vertex_b_z <= bz;
		vertex_c_x <= cx; vertex_c_y <= cy; vertex_c_z <= cz;
		center_x <= px; center_y <= py;
		center_z_and_radius <= {pz, rad};
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] value);
		start <= 1'b0;
		while (pending_answers != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random item: small triangle near the sphere, sometimes degenerate, or full-range noise.
	task automatic random_item(bit no_gap);
		crd_t base [3];
		crd_t v [12];
		int span, kind;
		logic [31:0] rad;
		kind = $urandom_range(9, 0);
		span = (kind < 4) ? 32'h0002_0000 : (kind < 7 ? 32'h0000_0400 : 8);
		for (int i = 0; i < 3; i++) base[i] = crd_t'($urandom);
		for (int i = 0; i < 12; i++) v[i] = near_crd(base[i % 3], span);
		// Occasionally collapse an edge or make the corners collinear.
		if (kind == 7) begin
			for (int i = 0; i < 3; i++) v[3 + i] = v[i] + crd_t'($urandom_range(1, 0));
		end else if (kind == 8) begin
			for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i] + (v[3 + i] - v[i]);
		end else if (kind == 9) begin
			for (int i = 0; i < 12; i++) v[i] = crd_t'($urandom);
		end
		rad = (kind == 9) ? $urandom : $urandom_range(2 * span, 0);
		send_item(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
			v[9], v[10], v[11], rad, no_gap);
	endtask

	localparam crd_t CMAX = 32'sh7FFF_FFFF;
	localparam crd_t CMIN = 32'sh8000_0000;
	localparam crd_t ONE = 32'sh0001_0000;

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, corner hit, point, short edges, flat, face, edges.
		send_item(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN,
			CMAX, CMIN, CMAX, 32'hFFFF_FFFF, 0);
		send_item(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX,
			CMIN, CMAX, CMIN, 32'd0, 0);
		send_item(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0);
		send_item(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0, ONE, 0);
		send_item(0, 0, 0, 0, 0, 0, 2 * ONE, 0, 0, ONE, ONE / 2, 0, ONE, 0);
		send_item(0, 0, 0, 2 * ONE, 0, 0, 2 * ONE, 0, 0, ONE, ONE / 2, 0, ONE, 1);
		send_item(2 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, ONE, ONE / 2, 0, ONE, 1);
		send_item(0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0, ONE, ONE / 2, 0, ONE, 0);
		send_item(0, 0, 0, 4 * ONE, 0, 0, 0, 4 * ONE, 0, ONE, ONE, ONE / 2, ONE, 0);
		send_item(0, 0, 0, 4 * ONE, 0, 0, 0, 4 * ONE, 0, ONE, ONE, 2 * ONE, ONE, 0);
		send_item(0, 0, 0, 4 * ONE, 0, 0, 0, 4 * ONE, 0, 2 * ONE, -ONE / 2, 0, ONE, 1);
		send_item(0, 0, 0, 4 * ONE, 0, 0, 0, 4 * ONE, 0, -ONE / 2, 2 * ONE, 0, ONE, 1);
		send_item(0, 0, 0, 4 * ONE, 0, 0, 0, 4 * ONE, 0, 3 * ONE, 3 * ONE, 0, ONE, 1);
		send_item(0, 0, 0, 4 * ONE, 0, 0, 0, 4 * ONE, 0, -2 * ONE, -2 * ONE, 0, ONE, 0);
		send_item(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);

		// Random phases across threshold settings, extremes included.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_threshold('0);
				1: write_threshold('1);
				2: write_threshold(THR_W'(1));
				3: write_threshold(THR_RST);
				default: write_threshold(THR_W'($urandom));
			endcase
			for (int n = 0; n < 150; n++) random_item(n % 50 < 15);
		end

		start <= 1'b0;
		while (pending_answers != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
